// ===== hw/rtl/scta_pkg.sv =====
// scta_pkg: scan codes, keymap table and shift remap for the scan-code decoder
`timescale 1ns / 1ps
package scta_pkg;

	localparam logic [7:0] CODE_LSHIFT = 8'h2A;
	localparam logic [7:0] CODE_RSHIFT = 8'h36;
	localparam logic [7:0] REL_LSHIFT  = 8'hAA;
	localparam logic [7:0] REL_RSHIFT  = 8'hB6;
	localparam logic [7:0] CODE_EXT    = 8'hE0;
	localparam logic [7:0] EXT_UP      = 8'h48;
	localparam logic [7:0] EXT_DOWN    = 8'h50;
	localparam logic [7:0] EXT_LEFT    = 8'h4B;
	localparam logic [7:0] EXT_RIGHT   = 8'h4D;

	localparam logic [6:0] CHAR_UP    = 7'h41;
	localparam logic [6:0] CHAR_DOWN  = 7'h42;
	localparam logic [6:0] CHAR_RIGHT = 7'h43;
	localparam logic [6:0] CHAR_LEFT  = 7'h44;
	localparam logic [6:0] CHAR_NONE  = 7'h00;

	typedef logic [7:0] scan_t;
	typedef logic [6:0] char_t;

	// decoder result for one item, plus the next flag values
	typedef struct packed {
		logic  has_char;
		char_t chr;
		logic  shift_next;
		logic  ext_next;
	} dec_t;

	function automatic char_t keymap(input logic [5:0] idx);
		char_t c;
		case (idx)
			6'h02: c = 7'h31;
			6'h03: c = 7'h32;
			6'h04: c = 7'h33;
			6'h05: c = 7'h34;
			6'h06: c = 7'h35;
			6'h07: c = 7'h36;
			6'h08: c = 7'h37;
			6'h09: c = 7'h38;
			6'h0A: c = 7'h39;
			6'h0B: c = 7'h30;
			6'h0C: c = 7'h2D;
			6'h0D: c = 7'h3D;
			6'h0E: c = 7'h08; // backspace
			6'h10: c = 7'h71;
			6'h11: c = 7'h77;
			6'h12: c = 7'h65;
			6'h13: c = 7'h72;
			6'h14: c = 7'h74;
			6'h15: c = 7'h79;
			6'h16: c = 7'h75;
			6'h17: c = 7'h69;
			6'h18: c = 7'h6F;
			6'h19: c = 7'h70;
			6'h1A: c = 7'h5B;
			6'h1B: c = 7'h5D;
			6'h1C: c = 7'h0A; // enter
			6'h1E: c = 7'h61;
			6'h1F: c = 7'h73;
			6'h20: c = 7'h64;
			6'h21: c = 7'h66;
			6'h22: c = 7'h67;
			6'h23: c = 7'h68;
			6'h24: c = 7'h6A;
			6'h25: c = 7'h6B;
			6'h26: c = 7'h6C;
			6'h27: c = 7'h3B;
			6'h28: c = 7'h27;
			6'h29: c = 7'h60;
			6'h2B: c = 7'h5C;
			6'h2C: c = 7'h7A;
			6'h2D: c = 7'h78;
			6'h2E: c = 7'h63;
			6'h2F: c = 7'h76;
			6'h30: c = 7'h62;
			6'h31: c = 7'h6E;
			6'h32: c = 7'h6D;
			6'h33: c = 7'h2C;
			6'h34: c = 7'h2E;
			6'h35: c = 7'h2F;
			6'h37: c = 7'h2A;
			6'h39: c = 7'h20; // space
			default: c = CHAR_NONE;
		endcase
		return c;
	endfunction

	function automatic char_t apply_shift(input char_t c);
		char_t r;
		if (c >= 7'h61 && c <= 7'h7A) begin
			r = c - 7'h20;
		end else begin
			case (c)
				7'h31: r = 7'h21;
				7'h32: r = 7'h40;
				7'h33: r = 7'h23;
				7'h34: r = 7'h24;
				7'h35: r = 7'h25;
				7'h36: r = 7'h5E;
				7'h37: r = 7'h26;
				7'h38: r = 7'h2A;
				7'h39: r = 7'h28;
				7'h30: r = 7'h29;
				7'h2D: r = 7'h5F;
				7'h3D: r = 7'h2B;
				7'h5B: r = 7'h7B;
				7'h5D: r = 7'h7D;
				7'h5C: r = 7'h7C;
				7'h3B: r = 7'h3A;
				7'h27: r = 7'h22;
				7'h2C: r = 7'h3C;
				7'h2E: r = 7'h3E;
				7'h2F: r = 7'h3F;
				default: r = c;
			endcase
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/scta_decode.sv =====
// scta_decode: combinational decode of one scan byte against the shift and prefix flags
`timescale 1ns / 1ps
module scta_decode
	import scta_pkg::*;
(
	input  scan_t byte_in,
	input  logic  shift_held,
	input  logic  ext_pending,
	output dec_t  dec
);

	char_t base_chr;
	char_t shifted_chr;

	// only codes below 0x40 with bit 7 clear hit the table
	assign base_chr    = (byte_in[7:6] == 2'b00) ? keymap(byte_in[5:0]) : CHAR_NONE;
	assign shifted_chr = shift_held ? apply_shift(base_chr) : base_chr;

	always_comb begin
		dec.has_char   = 1'b0;
		dec.chr        = CHAR_NONE;
		dec.shift_next = shift_held;
		dec.ext_next   = 1'b0;
		if (ext_pending) begin
			// byte after the prefix is always consumed here
			case (byte_in)
				EXT_UP:    dec.chr = CHAR_UP;
				EXT_DOWN:  dec.chr = CHAR_DOWN;
				EXT_RIGHT: dec.chr = CHAR_RIGHT;
				EXT_LEFT:  dec.chr = CHAR_LEFT;
				default:   dec.chr = CHAR_NONE;
			endcase
			dec.has_char = (dec.chr != CHAR_NONE);
		end else if (byte_in == CODE_LSHIFT || byte_in == CODE_RSHIFT) begin
			dec.shift_next = 1'b1;
		end else if (byte_in == REL_LSHIFT || byte_in == REL_RSHIFT) begin
			dec.shift_next = 1'b0;
		end else if (byte_in == CODE_EXT) begin
			dec.ext_next = 1'b1;
		end else begin
			dec.chr      = shifted_chr;
			dec.has_char = (base_chr != CHAR_NONE);
		end
	end

endmodule

// ===== hw/rtl/scancode_to_ascii_decoder.sv =====
// scancode_to_ascii_decoder: scan-code set 1 byte stream to ascii characters
//
// input channel: scan_valid / scan_stall carry one scan byte per item.
// output channel: char_valid / char_stall carry one ascii character per item.
// an item is taken at a clock edge with valid high and stall low.
// every input item yields zero or one output item; shift codes, the extended
// prefix, break codes and unmapped keys give none.
// path: the byte lands in the input register at the accept edge and its character
// in the result register once that register is free, with the decode table
// between them; char_valid rises as the result register is loaded.
// throughput: one item per cycle unless the receiver stalls; the input register
// holds the next byte while a decoded character waits in the result register.
// when the receiver stalls, the result register holds its character and the
// input register fills; scan_stall rises only when both are occupied and the
// held byte would produce a character. items with no result drain regardless.
// reset clears the shift and prefix flags and empties both registers.
`timescale 1ns / 1ps
module scancode_to_ascii_decoder
	import scta_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan_valid,
	output logic       scan_stall,
	input  logic [7:0] scan_byte,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [6:0] char_code
);

	logic  valid_s1;
	scan_t byte_s1;
	logic  shift_q;
	logic  ext_q;
	logic  out_free;
	logic  adv;
	logic  scan_take;
	dec_t  dec;

	scta_decode u_decode (
		.byte_in     (byte_s1),
		.shift_held  (shift_q),
		.ext_pending (ext_q),
		.dec         (dec)
	);

	assign out_free   = !char_valid || !char_stall;
	// items with no character do not need the result register
	assign adv        = valid_s1 && (!dec.has_char || out_free);
	assign scan_stall = valid_s1 && !adv;
	assign scan_take  = scan_valid && !scan_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= scan_take || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (scan_take) begin
			byte_s1 <= scan_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			ext_q   <= 1'b0;
		end else if (adv) begin
			shift_q <= dec.shift_next;
			ext_q   <= dec.ext_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
		end else if (out_free) begin
			char_valid <= adv && dec.has_char;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv && dec.has_char) begin
			char_code <= dec.chr;
		end
	end

	a_no_zero_char: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> char_code != CHAR_NONE)
		else $error("zero character on output");

	a_ext_gives_arrow: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ext_q && dec.has_char) |=> char_valid &&
			(char_code == CHAR_UP || char_code == CHAR_DOWN ||
			 char_code == CHAR_RIGHT || char_code == CHAR_LEFT))
		else $error("extended code did not decode to a cursor character");

	a_stall_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		scan_stall |-> valid_s1 && dec.has_char && char_valid && char_stall)
		else $error("input stalled without a blocked result");

	a_shift_make: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !ext_q && (byte_s1 == CODE_LSHIFT || byte_s1 == CODE_RSHIFT)) |=> shift_q)
		else $error("shift make code did not set shift flag");

	a_prefix_one_shot: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ext_q) |=> !ext_q)
		else $error("prefix flag survived the extended byte");

endmodule

// ===== tb/scan_char_checker.sv =====
// scan_char_checker: watches both channels of the scan-code decoder, predicts and compares
`timescale 1ns / 1ps
module scan_char_checker
	import scta_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan_valid,
	input  logic       scan_stall,
	input  logic [7:0] scan_byte,
	input  logic       char_valid,
	input  logic       char_stall,
	input  logic [6:0] char_code,
	output int         errors,
	output int         pending,
	output int         items_seen,
	output int         chars_seen,
	output int         arrows_seen
);

	localparam logic [7:0] KEY_BKSP  = 8'h0E;
	localparam logic [7:0] KEY_ENTER = 8'h1C;
	localparam logic [7:0] ASCII_BS  = 8'h08;
	localparam logic [7:0] ASCII_LF  = 8'h0A;
	localparam logic [7:0] NO_KEY    = "~";

	// make codes 0x00..0x3f, one row of sixteen per string; "~" marks no key
	localparam logic [8*64-1:0] KEY_ROWS = {
		"~~1234567890-=~~",
		"qwertyuiop[]~~as",
		"dfghjkl;'`~\\zxcv",
		"bnm,./~*~ ~~~~~~"
	};
	localparam logic [8*20-1:0] PUNCT_PLAIN   = "1234567890-=[]\\;',./";
	localparam logic [8*20-1:0] PUNCT_SHIFTED = "!@#$%^&*()_+{}|:\"<>?";

	logic  shift_down;
	logic  ext_armed;
	char_t expected_chars [$];

	function automatic logic [7:0] plain_char(input logic [5:0] idx);
		logic [7:0] ch;
		ch = KEY_ROWS[8*(63 - int'(idx)) +: 8];
		if (idx == KEY_BKSP[5:0]) begin
			ch = ASCII_BS;
		end else if (idx == KEY_ENTER[5:0]) begin
			ch = ASCII_LF;
		end else if (ch == NO_KEY) begin
			ch = 8'h00;
		end
		return ch;
	endfunction

	function automatic logic [7:0] shifted_char(input logic [7:0] ch);
		logic [7:0] r;
		r = ch;
		if (ch >= "a" && ch <= "z") begin
			r = ch - 8'h20;
		end else begin
			for (int i = 0; i < 20; i++) begin
				if (PUNCT_PLAIN[8*i +: 8] == ch)
					r = PUNCT_SHIFTED[8*i +: 8];
			end
		end
		return r;
	endfunction

	// advances the shift and prefix flags; returns 1 when a character comes out
	function automatic logic decode_scan(input scan_t b, output char_t chr);
		logic [7:0] ch;
		chr = CHAR_NONE;
		ch = 8'h00;
		if (ext_armed) begin
			// byte after the prefix is always consumed here
			ext_armed = 1'b0;
			case (b)
				EXT_UP:    chr = CHAR_UP;
				EXT_DOWN:  chr = CHAR_DOWN;
				EXT_RIGHT: chr = CHAR_RIGHT;
				EXT_LEFT:  chr = CHAR_LEFT;
				default:   chr = CHAR_NONE;
			endcase
			return chr != CHAR_NONE;
		end
		if (b == CODE_LSHIFT || b == CODE_RSHIFT) begin
			shift_down = 1'b1;
			return 1'b0;
		end
		if (b == REL_LSHIFT || b == REL_RSHIFT) begin
			shift_down = 1'b0;
			return 1'b0;
		end
		if (b == CODE_EXT) begin
			ext_armed = 1'b1;
			return 1'b0;
		end
		if (b[7] || b[6])
			return 1'b0;
		ch = plain_char(b[5:0]);
		if (ch == 8'h00)
			return 1'b0;
		if (shift_down)
			ch = shifted_char(ch);
		chr = ch[6:0];
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		char_t chr;
		char_t want;
		logic  was_ext;
		if (!arst_n) begin
			shift_down = 1'b0;
			ext_armed = 1'b0;
			expected_chars.delete();
			errors = 0;
			pending = 0;
			items_seen = 0;
			chars_seen = 0;
			arrows_seen = 0;
		end else begin
			// results first: an item taken at this edge cannot answer yet
			if (char_valid && !char_stall) begin
				chars_seen = chars_seen + 1;
				if (expected_chars.size() == 0) begin
					errors = errors + 1;
					$display("%0t: unexpected char_code 0x%h, nothing expected",
						$time, char_code);
				end else begin
					want = expected_chars.pop_front();
					if (want !== char_code) begin
						errors = errors + 1;
						$display("%0t: char_code mismatch: expected 0x%h, got 0x%h",
							$time, want, char_code);
					end
				end
			end
			if (scan_valid && !scan_stall) begin
				items_seen = items_seen + 1;
				was_ext = ext_armed;
				if (decode_scan(scan_byte, chr)) begin
					expected_chars.push_back(chr);
					if (was_ext)
						arrows_seen = arrows_seen + 1;
				end
			end
			pending = expected_chars.size();
		end
	end

endmodule

// ===== tb/tb_scancode_to_ascii_decoder.sv =====
// tb_scancode_to_ascii_decoder: stimulus, receiver stalls and verdict for the scan-code decoder
`timescale 1ns / 1ps
module tb_scancode_to_ascii_decoder
	import scta_pkg::*;
();

	localparam int RANDOM_ITEMS = 800;
	localparam int DIRECTED_ITEMS = 28;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       scan_valid = 1'b0;
	logic [7:0] scan_byte = 8'h00;
	logic       char_stall = 1'b0;
	logic       scan_stall;
	logic       char_valid;
	logic [6:0] char_code;

	int errors;
	int pending;
	int items_seen;
	int chars_seen;
	int arrows_seen;

	int cycle_count = 0;
	int burst_left = 0;
	int sent = 0;
	int stall_left = 0;
	int stall_mode = 0;
	logic drained_once = 1'b0;

	// extremes, every cursor key, dropped bytes after the prefix, shifted keys
	scan_t directed_seq [DIRECTED_ITEMS] = '{
		8'h00, 8'hFF, 8'h40, 8'h1E,
		CODE_EXT, EXT_UP, CODE_EXT, EXT_DOWN, CODE_EXT, EXT_RIGHT, CODE_EXT, EXT_LEFT,
		CODE_EXT, CODE_LSHIFT, 8'h1E,
		CODE_EXT, CODE_EXT, 8'h1E,
		CODE_RSHIFT, CODE_EXT, REL_RSHIFT,
		8'h10, 8'h02, 8'h2B, 8'h39, 8'h1C, 8'h0E,
		REL_LSHIFT
	};

	scancode_to_ascii_decoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_valid (scan_valid),
		.scan_stall (scan_stall),
		.scan_byte  (scan_byte),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code)
	);

	scan_char_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.scan_valid  (scan_valid),
		.scan_stall  (scan_stall),
		.scan_byte   (scan_byte),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_code   (char_code),
		.errors      (errors),
		.pending     (pending),
		.items_seen  (items_seen),
		.chars_seen  (chars_seen),
		.arrows_seen (arrows_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver: stretches of free flow, light, heavy and periodic stalls
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       char_stall <= 1'b0;
			1:       char_stall <= ($urandom_range(0, 3) == 0);
			2:       char_stall <= ($urandom_range(0, 3) != 0);
			default: char_stall <= (stall_left[3:0] < 4'd10);
		endcase
	end

	// called at a rising edge; returns at the edge where the item is taken
	task automatic send_scan(input scan_t b);
		if (burst_left == 0) begin
			scan_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 10);
		end
		burst_left = burst_left - 1;
		scan_valid <= 1'b1;
		scan_byte <= b;
		@(negedge clk);
		while (scan_stall)
			@(negedge clk);
		@(posedge clk);
		sent = sent + 1;
	endtask

	// mostly key presses and shift sequences, some prefix pairs, breaks and noise
	task automatic send_random_key();
		int    pick;
		scan_t b;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			b = scan_t'($urandom_range(0, 63));
			send_scan(b);
		end else if (pick < 55) begin
			send_scan($urandom_range(0, 1) ? CODE_LSHIFT : CODE_RSHIFT);
		end else if (pick < 63) begin
			send_scan($urandom_range(0, 1) ? REL_LSHIFT : REL_RSHIFT);
		end else if (pick < 75) begin
			send_scan(CODE_EXT);
			case ($urandom_range(0, 5))
				0:       b = EXT_UP;
				1:       b = EXT_DOWN;
				2:       b = EXT_RIGHT;
				3:       b = EXT_LEFT;
				default: b = scan_t'($urandom_range(0, 255));
			endcase
			send_scan(b);
		end else if (pick < 85) begin
			b = scan_t'($urandom_range(0, 63));
			send_scan(b | 8'h80);
		end else begin
			b = scan_t'($urandom_range(0, 255));
			send_scan(b);
		end
	endtask

	task automatic wait_for_chars();
		scan_valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_seq[i])
			send_scan(directed_seq[i]);
		while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			if (!drained_once && sent >= DIRECTED_ITEMS + RANDOM_ITEMS / 2) begin
				wait_for_chars();
				drained_once = 1'b1;
			end
			send_random_key();
		end
		wait_for_chars();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		$display("covered %0d scan bytes with shift, prefix, break and noise traffic",
			items_seen);
		$display("checked %0d decoded characters, %0d of them cursor keys",
			chars_seen, arrows_seen);
		if (errors == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
